[rtl/rpnp_pkg.sv]
// Shared types and constants for the radix-prefixed number parser.
package rpnp_pkg;

    localparam int unsigned OUT_BITS = 64;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;

    typedef logic [1:0] radix_mode_t;
    localparam radix_mode_t MODE_DEC = 2'd0;
    localparam radix_mode_t MODE_BIN = 2'd1;
    localparam radix_mode_t MODE_HEX = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_NODIGITS = 2'd1;
    localparam status_t ST_BADDIGIT = 2'd2;

    typedef logic [1:0] op_t;
    localparam op_t OP_PREFIX = 2'd0;
    localparam op_t OP_DIGIT  = 2'd1;
    localparam op_t OP_BAD    = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [3:0]  digit;
        radix_mode_t mode;
        logic        first;
        logic        last;
    } word_t;

endpackage

[rtl/rpnp_front.sv]
// Front end: accepts text bytes, tracks the token radix and classifies each byte.
module rpnp_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    text_byte,
    input  logic          last_byte,
    input  logic          q_ready,
    output logic          q_valid,
    output rpnp_pkg::word_t q_word
);
    import rpnp_pkg::*;

    logic        start_reg;
    logic        start_next;
    radix_mode_t mode_reg;
    radix_mode_t mode_next;
    radix_mode_t mode_cur;
    logic        is_prefix;
    logic [4:0]  dval;
    logic        fits;
    logic        accept;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
            r = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            r = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66)
            r = 5'(c - 8'h61 + 8'd10);
        return r;
    endfunction

    assign accept   = in_valid && q_ready;
    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        is_prefix = 1'b0;
        mode_cur  = mode_reg;
        if (start_reg)
        begin
            priority if (text_byte == CHAR_PERCENT)
            begin
                is_prefix = 1'b1;
                mode_cur  = MODE_BIN;
            end
            else if (text_byte == CHAR_DOLLAR)
            begin
                is_prefix = 1'b1;
                mode_cur  = MODE_HEX;
            end
            else
            begin
                mode_cur = MODE_DEC;
            end
        end
        dval = digit_of(text_byte);
        unique case (mode_cur)
            MODE_BIN: fits = (dval < 5'd2);
            MODE_HEX: fits = (dval < 5'd16);
            default:  fits = (dval < 5'd10);
        endcase
        q_word.digit = dval[3:0];
        q_word.mode  = mode_cur;
        q_word.first = start_reg;
        q_word.last  = last_byte;
        priority if (is_prefix)
            q_word.op = OP_PREFIX;
        else if (fits)
            q_word.op = OP_DIGIT;
        else
            q_word.op = OP_BAD;
    end

    always_comb
    begin
        start_next = start_reg;
        mode_next  = mode_reg;
        if (accept)
        begin
            start_next = last_byte;
            mode_next  = last_byte ? MODE_DEC : mode_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            mode_reg  <= MODE_DEC;
        end
        else
        begin
            start_reg <= start_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

[rtl/rpnp_queue.sv]
// Short queue of classified words between the front and back ends.
module rpnp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rpnp_pkg::word_t wr_word,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rpnp_pkg::word_t rd_word
);
    import rpnp_pkg::*;

    word_t                     slot_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_next;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;
    logic                      push;
    logic                      pop;

    function automatic logic [QUEUE_IDX_BITS-1:0] bump(input logic [QUEUE_IDX_BITS-1:0] p);
        logic [QUEUE_IDX_BITS-1:0] r;
        if (p == QUEUE_IDX_BITS'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign wr_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_word  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/rpnp_back.sv]
// Back end: accumulates digits, keeps the sticky error and holds the result word.
module rpnp_back
#(
    parameter int unsigned VALUE_BITS = 64
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  rpnp_pkg::word_t                 q_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rpnp_pkg::OUT_BITS-1:0]   number_value,
    output rpnp_pkg::status_t               parse_status
);
    import rpnp_pkg::*;

    logic [VALUE_BITS-1:0] acc_reg;
    logic [VALUE_BITS-1:0] acc_next;
    status_t               err_reg;
    status_t               err_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_BITS-1:0]   value_reg;
    logic [OUT_BITS-1:0]   value_next;
    status_t               status_reg;
    status_t               status_next;
    logic [VALUE_BITS-1:0] acc_base;
    status_t               err_base;
    logic [VALUE_BITS-1:0] scaled;
    logic                  pop;

    assign q_ready      = !q_word.last || !out_valid_reg || out_ready;
    assign pop          = q_valid && q_ready;
    assign out_valid    = out_valid_reg;
    assign number_value = value_reg;
    assign parse_status = status_reg;

    always_comb
    begin
        acc_base = q_word.first ? '0 : acc_reg;
        err_base = q_word.first ? ST_OK : err_reg;
        unique case (q_word.mode)
            MODE_BIN: scaled = VALUE_BITS'(acc_base << 1);
            MODE_HEX: scaled = VALUE_BITS'(acc_base << 4);
            default:  scaled = VALUE_BITS'(acc_base << 3) + VALUE_BITS'(acc_base << 1);
        endcase

        acc_next = acc_base;
        err_next = err_base;
        if (err_base == ST_OK)
        begin
            unique case (q_word.op)
                OP_PREFIX:
                begin
                    acc_next = '0;
                    err_next = q_word.last ? ST_NODIGITS : ST_OK;
                end
                OP_DIGIT:
                begin
                    acc_next = scaled + VALUE_BITS'(q_word.digit);
                end
                default:
                begin
                    acc_next = '0;
                    err_next = ST_BADDIGIT;
                end
            endcase
        end

        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        status_next    = status_reg;
        if (pop && q_word.last)
        begin
            out_valid_next = 1'b1;
            value_next     = (err_next == ST_OK) ? OUT_BITS'(acc_next) : '0;
            status_next    = err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            acc_reg <= acc_next;
            err_reg <= err_next;
        end
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

endmodule

[rtl/radix_prefixed_number_parser_core.sv]
// Top level of the radix-prefixed number parser.
//
// Input channel (in_valid/in_ready): one text_byte per word, last_byte set on
// the final character of a token. A leading '%' selects binary, a leading '$'
// hexadecimal, anything else decimal. Digits accumulate modulo 2^VALUE_BITS.
// Output channel (out_valid/out_ready): one word per token, carrying
// number_value (zero-extended to 64 bits, zero on error) and parse_status
// (0 ok, 1 prefix without digits, 2 invalid digit).
// Throughput: one byte per cycle while the queue has room, set by the single
// multiply-by-radix and add in the back end. The last byte of a token is
// written into the two-word queue when it is accepted and moves into the
// result register when the back end pops it from the queue.
// Reset: the token state returns to first-character, the queue empties and
// no result is pending.
// Stall: while a result waits, non-last bytes keep flowing through; the queue
// fills on the next last byte and in_ready drops once it holds two words.
module radix_prefixed_number_parser_core
#(
    parameter int unsigned VALUE_BITS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] number_value,
    output logic [1:0]  parse_status
);
    import rpnp_pkg::*;

    word_t   front_word;
    logic    front_valid;
    logic    front_ready;
    word_t   back_word;
    logic    back_valid;
    logic    back_ready;
    status_t status;

    rpnp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .q_ready   (front_ready),
        .q_valid   (front_valid),
        .q_word    (front_word)
    );

    rpnp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_word  (front_word),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_word  (back_word)
    );

    rpnp_back #(.VALUE_BITS(VALUE_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (back_valid),
        .q_ready      (back_ready),
        .q_word       (back_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .number_value (number_value),
        .parse_status (status)
    );

    assign parse_status = status;

endmodule

[rtl/rpnp_checker.sv]
// Port-level checker for the radix-prefixed number parser, with its bind.
module rpnp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] number_value,
    input logic [1:0]  parse_status
);
    import rpnp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(number_value)
            && $stable(parse_status))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> parse_status == ST_OK || parse_status == ST_NODIGITS
            || parse_status == ST_BADDIGIT)
        else $error("undefined parse status");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && parse_status != ST_OK |-> number_value == '0)
        else $error("nonzero value with error status");

endmodule

bind radix_prefixed_number_parser_core rpnp_checker u_rpnp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .number_value (number_value),
    .parse_status (parse_status)
);

[tb/tb_radix_prefixed_number_parser_core.sv]
// Self-checking testbench for the radix-prefixed number parser core.
module tb_radix_prefixed_number_parser_core;
    import rpnp_pkg::*;

    localparam int unsigned VALUE_BITS = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } parse_result_t;

    class parse_scoreboard;
        bit            tok_start;
        radix_mode_t   mode;
        logic [63:0]   acc;
        status_t       err;
        parse_result_t expected_results[$];
        int            errors;

        function new();
            tok_start = 1'b1;
            mode = MODE_DEC;
            acc = '0;
            err = ST_OK;
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function logic [63:0] value_mask();
            return {64{1'b1}} >> (64 - VALUE_BITS);
        endfunction

        function logic [4:0] digit_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return 5'(c - "0");
            if (c >= "A" && c <= "F")
                return 5'(c - "A" + 8'd10);
            if (c >= "a" && c <= "f")
                return 5'(c - "a" + 8'd10);
            return 5'd16;
        endfunction

        function void fold_digit(logic [7:0] c);
            logic [4:0]  d;
            logic [63:0] radix;
            radix = (mode == MODE_BIN) ? 64'd2 : (mode == MODE_HEX) ? 64'd16 : 64'd10;
            d = digit_value(c);
            if (err != ST_OK)
                return;
            if (d >= radix)
            begin
                err = ST_BADDIGIT;
                acc = '0;
                return;
            end
            acc = (acc * radix + d) & value_mask();
        endfunction

        function void note_input(logic [7:0] c, logic last);
            parse_result_t r;
            if (tok_start)
            begin
                tok_start = 1'b0;
                acc = '0;
                err = ST_OK;
                if (c == CHAR_PERCENT)
                begin
                    mode = MODE_BIN;
                    if (last)
                        err = ST_NODIGITS;
                end
                else if (c == CHAR_DOLLAR)
                begin
                    mode = MODE_HEX;
                    if (last)
                        err = ST_NODIGITS;
                end
                else
                begin
                    mode = MODE_DEC;
                    fold_digit(c);
                end
            end
            else
                fold_digit(c);
            if (last)
            begin
                r.value = (err == ST_OK) ? (acc & value_mask()) : 64'd0;
                r.status = err;
                expected_results.push_back(r);
                tok_start = 1'b1;
                mode = MODE_DEC;
                acc = '0;
                err = ST_OK;
            end
        endfunction

        function void check_result(logic [63:0] v, status_t s);
            parse_result_t r;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected word, value %h status %0d", $time, v, s);
                errors++;
                return;
            end
            r = expected_results.pop_front();
            if (r.value !== v)
            begin
                $display("%0t: number_value expected %h actual %h", $time, r.value, v);
                errors++;
            end
            if (r.status !== s)
            begin
                $display("%0t: parse_status expected %0d actual %0d", $time, r.status, s);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] number_value;
    logic [1:0]  parse_status;

    parse_scoreboard sb;
    logic [7:0]      token_chars[$];
    int              send_idle = 0;
    int              recv_stall = 0;
    int              hold_cycles = 0;
    int              items_sent = 0;
    int              cycle_count = 0;
    int              idle_send[4] = '{0, 46, 0, 20};
    int              idle_recv[4] = '{0, 0, 46, 20};

    radix_prefixed_number_parser_core #(.VALUE_BITS(VALUE_BITS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .number_value (number_value),
        .parse_status (parse_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (in_valid && in_ready)
                sb.note_input(text_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_result(number_value, parse_status);
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready = 1'b0;
                hold_cycles--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_byte(logic [7:0] c, logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        text_byte = c;
        last_byte = last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_token();
        int i;
        for (i = 0; i < token_chars.size(); i++)
            send_byte(token_chars[i], i == token_chars.size() - 1);
    endtask

    task automatic parse_text(string s);
        int i;
        token_chars = {};
        for (i = 0; i < s.len(); i++)
            token_chars.push_back(s[i]);
        send_token();
    endtask

    task automatic gen_random_token();
        int         kind;
        int         radix_sel;
        int         len;
        int         pos;
        int         i;
        int         d;
        logic [7:0] ch;
        token_chars = {};
        kind = $urandom_range(99);
        if (kind >= 90)
        begin
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++)
                token_chars.push_back(8'($urandom_range(255)));
            return;
        end
        radix_sel = $urandom_range(2);
        if ($urandom_range(9) < 8)
            len = $urandom_range(1, 6);
        else if (radix_sel == 1)
            len = $urandom_range(60, 70);
        else
            len = $urandom_range(16, 24);
        if (radix_sel != 0 && $urandom_range(19) == 0)
            len = 0;
        if (radix_sel == 1)
            token_chars.push_back(CHAR_PERCENT);
        else if (radix_sel == 2)
            token_chars.push_back(CHAR_DOLLAR);
        for (i = 0; i < len; i++)
        begin
            if (radix_sel == 1)
                d = $urandom_range(1);
            else if (radix_sel == 2)
                d = $urandom_range(15);
            else
                d = $urandom_range(9);
            if (d < 10)
                ch = 8'("0" + d);
            else
                ch = 8'(($urandom_range(1) ? "a" : "A") + d - 10);
            token_chars.push_back(ch);
        end
        if (kind >= 80)
        begin
            pos = $urandom_range(token_chars.size() - 1);
            token_chars[pos] = 8'($urandom_range(255));
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int target;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_byte = 8'h00;
        last_byte = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        parse_text("%");
        parse_text("$");
        parse_text("0");
        parse_text("9");
        parse_text("%101");
        parse_text("$fF");
        parse_text("$G");
        parse_text("%2");
        parse_text("A");
        token_chars = {8'h00};
        send_token();
        token_chars = {8'hFF};
        send_token();
        parse_text("2x5");
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle = idle_send[phase];
            recv_stall = idle_recv[phase];
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
            begin
                gen_random_token();
                send_token();
            end
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        hold_cycles = 300;
        repeat (30)
        begin
            gen_random_token();
            send_token();
        end
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
